// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and defaults of the block bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int MAP_BYTES_DEF = 512;
	localparam int WORD_BITS     = 32;
	localparam int KIND_W        = 2;
	localparam int INDEX_W       = 12;
	localparam int RES_W         = 7;
	localparam int INDEX_SPAN    = 4096;

	localparam logic [RES_W-1:0] RES_RESET = 7'd7;

	typedef enum logic [KIND_W-1:0] {
		KIND_USE  = 2'd0,
		KIND_FREE = 2'd1,
		KIND_FIND = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

endpackage

// ===== sv/block_bitmap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// block_bitmap_allocator_core
// Allocation bitmap in a 32-bit synchronous RAM: mark used, mark free, and
// find the lowest free entry at or above reserved_low.
// ----------------------------------------------------------------------------
//  channel  | ports                            | handshake
//  command  | kind, entry_index                | start & !busy
//  result   | found, free_index                | done, one cycle, no stall
//  config   | cfg_wdata (reserved_low)         | cfg_we
//
//  Mark: read, then modify and write back the 32-bit word.
//  Unused kind, out-of-range mark, find with reserved_low past the end: done from idle.
//  Find: k words read at one RAM read per cycle, up to 128.
//  Reset runs a clearing pass over all (MAP_BYTES+3)/4 words with busy high.
//  busy blocks new commands, which also keeps RAM accesses from overlapping.
module block_bitmap_allocator_core #(
	parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bba_pkg::KIND_W-1:0]  kind,
	input  logic [bba_pkg::INDEX_W-1:0] entry_index,
	output logic                        done,
	output logic                        found,
	output logic [bba_pkg::INDEX_W-1:0] free_index,
	input  logic                        cfg_we,
	input  logic [bba_pkg::RES_W-1:0]   cfg_wdata
);
	import bba_pkg::*;

	localparam int TOTAL     = MAP_BYTES * 8;
	localparam int LIMIT     = (TOTAL < INDEX_SPAN) ? TOTAL : INDEX_SPAN;
	localparam int WORDS     = (MAP_BYTES + 3) / 4;
	localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LAST_SCAN = (LIMIT - 1) / WORD_BITS;

	localparam logic [16:0]        TOTAL_L  = 17'(TOTAL);
	localparam logic [INDEX_W:0]   LIMIT_L  = (INDEX_W + 1)'(LIMIT);
	localparam logic [AW-1:0]      LAST_W   = AW'(LAST_SCAN);
	localparam logic [AW-1:0]      LAST_CLR = AW'(WORDS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SCAN
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          clr_q;
	logic [AW-1:0]          scan_q;
	logic                   done_q;
	logic                   found_q;
	logic [INDEX_W-1:0]     free_index_q;
	logic [RES_W-1:0]       reserved_low_q;

	logic                   op_set_q;
	logic [AW-1:0]          op_addr_q;
	logic [4:0]             op_bit_q;

	logic [WORD_BITS-1:0]   mem [WORDS];
	logic [WORD_BITS-1:0]   rdata_q;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [WORD_BITS-1:0]   mem_wdata;
	logic [AW-1:0]          mem_raddr;

	logic [AW-1:0]          entry_word;
	logic [AW-1:0]          start_word;
	logic                   entry_ok;
	logic                   res_past;
	logic [INDEX_W-1:0]     idx_base;
	logic [WORD_BITS-1:0]   cand;
	logic                   hit;
	logic [4:0]             pos;
	logic [WORD_BITS-1:0]   bit_mask;

	assign entry_word = AW'({{AW{1'b0}}, entry_index[INDEX_W-1:5]});
	assign start_word = AW'(reserved_low_q >> 5);
	assign entry_ok   = 17'(entry_index) < TOTAL_L;
	assign res_past   = (INDEX_W + 1)'(reserved_low_q) >= LIMIT_L;
	assign idx_base   = INDEX_W'({scan_q, 5'b0});
	assign bit_mask   = WORD_BITS'(1) << op_bit_q;

	// free and in-window bits of the word under scan, lowest one wins
	always_comb begin
		logic [INDEX_W-1:0] n;
		n    = '0;
		cand = '0;
		pos  = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			n       = idx_base + INDEX_W'(b);
			cand[b] = !rdata_q[b] && ({1'b0, n} >= (INDEX_W + 1)'(reserved_low_q))
				&& ({1'b0, n} < LIMIT_L);
		end
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				pos = 5'(b);
			end
		end
		hit = |cand;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = op_addr_q;
		mem_wdata = op_set_q ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
		mem_raddr = entry_word;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_MOD: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				mem_raddr = (kind == KIND_FIND) ? start_word : entry_word;
			end
			ST_SCAN: begin
				mem_raddr = scan_q + AW'(1);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_set_q  <= (kind == KIND_USE);
			op_addr_q <= entry_word;
			op_bit_q  <= entry_index[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			scan_q         <= '0;
			done_q         <= 1'b0;
			found_q        <= 1'b0;
			free_index_q   <= '0;
			reserved_low_q <= RES_RESET;
		end else begin
			if (cfg_we) begin
				reserved_low_q <= cfg_wdata;
			end
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_CLR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (kind)
							KIND_USE, KIND_FREE: begin
								if (entry_ok) begin
									state_q <= ST_MOD;
								end else begin
									done_q       <= 1'b1;
									found_q      <= 1'b0;
									free_index_q <= '0;
								end
							end
							KIND_FIND: begin
								if (res_past) begin
									done_q       <= 1'b1;
									found_q      <= 1'b0;
									free_index_q <= '0;
								end else begin
									scan_q  <= start_word;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								done_q       <= 1'b1;
								found_q      <= 1'b0;
								free_index_q <= '0;
							end
						endcase
					end
				end
				ST_MOD: begin
					done_q       <= 1'b1;
					found_q      <= 1'b0;
					free_index_q <= '0;
					state_q      <= ST_IDLE;
				end
				ST_SCAN: begin
					if (hit) begin
						done_q       <= 1'b1;
						found_q      <= 1'b1;
						free_index_q <= idx_base + INDEX_W'(pos);
						state_q      <= ST_IDLE;
					end else if (scan_q == LAST_W) begin
						done_q       <= 1'b1;
						found_q      <= 1'b0;
						free_index_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						scan_q <= scan_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign found      = found_q;
	assign free_index = free_index_q;

endmodule

// ===== sv/bba_chk.sv =====
// ----------------------------------------------------------------------------
// bba_chk
// Port-level checks of the block bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic                        found,
	input logic [bba_pkg::INDEX_W-1:0] free_index
);
	import bba_pkg::*;

	`CHK_NOW(a_miss_zero, done && !found, free_index == '0, "miss with nonzero index")
	`CHK_NEXT(a_accept_moves, start && !busy, busy || done, "accepted word went nowhere")
	`CHK_NEXT(a_idle_quiet, !busy && !start, !done, "result without a command")
	`CHK_NOW(a_done_idle, done, !busy, "result while still busy")

endmodule

bind block_bitmap_allocator_core bba_chk u_bba_chk (.*);
